[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed: label");
// Implication with the consequent in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed: label");
`endif

[src/tslf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tire slip package
// Angle constants, the arctangent table and shared types.
// ----------------------------------------------------------------------------
package tslf_pkg;
	localparam int AtanLen = 24;
	localparam int AngW = 34;
	localparam logic signed [AngW-1:0] AngPi = 34'sd843314856;
	localparam logic signed [AngW-1:0] AngHalfPi = 34'sd421657428;
	localparam logic signed [AngW-1:0] AngTwoPi = 34'sd1686629713;
	localparam logic signed [AngW-1:0] InvGain = 34'sd163008219;
	// Vector datapath width: vx and yf reach about 2^33, growth adds a bit or two.
	localparam int VecW = 44;

	typedef logic signed [AngW-1:0] ang_t;
	typedef logic signed [VecW-1:0] vec_t;

	// One CORDIC lane as it travels down the row of cells.
	typedef struct packed {
		vec_t x;
		vec_t y;
		ang_t z;
	} cordic_t;

	function automatic ang_t atan_entry(input int i);
		ang_t r;
		case (i)
			0: r = 34'sd210828714;
			1: r = 34'sd124459457;
			2: r = 34'sd65760959;
			3: r = 34'sd33381290;
			4: r = 34'sd16755422;
			5: r = 34'sd8385879;
			6: r = 34'sd4193963;
			7: r = 34'sd2097109;
			8: r = 34'sd1048571;
			9: r = 34'sd524287;
			default: r = (i < AtanLen) ? ang_t'(34'sd1 <<< (28 - i)) : '0;
		endcase
		return r;
	endfunction
endpackage

[src/tslf_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC cell
// One registered CORDIC micro-rotation; vectoring or rotation mode.
// ----------------------------------------------------------------------------
module tslf_cell #(
	parameter int STAGE = 0,
	parameter bit ROTATE = 1'b0,
	parameter int SIDE_W = 8
) (
	input  logic                       clk,
	input  logic                       en,
	input  tslf_pkg::cordic_t          d,
	input  logic [SIDE_W-1:0]          side_d,
	output tslf_pkg::cordic_t          q,
	output logic [SIDE_W-1:0]          side_q
);
	import tslf_pkg::*;

	localparam bit ACTIVE = (STAGE < AtanLen);
	localparam ang_t ATAN_I = atan_entry(STAGE);

	cordic_t nxt;
	logic    up;

	always_comb begin
		nxt = d;
		up = ROTATE ? (d.z >= 0) : (d.y >= 0);
		if (ACTIVE) begin
			// Arithmetic right shift rounds toward minus infinity.
			if (ROTATE ? up : !up) begin
				nxt.x = d.x - (d.y >>> STAGE);
				nxt.y = d.y + (d.x >>> STAGE);
			end else begin
				nxt.x = d.x + (d.y >>> STAGE);
				nxt.y = d.y - (d.x >>> STAGE);
			end
			nxt.z = (ROTATE ? !up : up) ? d.z + ATAN_I : d.z - ATAN_I;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
			side_q <= side_d;
		end
	end
endmodule

[src/tslf_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC chain
// A row of CORDIC cells, one per iteration, with side data carried along.
// ----------------------------------------------------------------------------
module tslf_chain #(
	parameter int STAGES = 16,
	parameter bit ROTATE = 1'b0,
	parameter int SIDE_W = 8
) (
	input  logic                clk,
	input  logic                en,
	input  tslf_pkg::cordic_t   d,
	input  logic [SIDE_W-1:0]   side_d,
	output tslf_pkg::cordic_t   q,
	output logic [SIDE_W-1:0]   side_q
);
	import tslf_pkg::*;

	cordic_t           lane [STAGES+1];
	logic [SIDE_W-1:0] side [STAGES+1];

	assign lane[0] = d;
	assign side[0] = side_d;

	for (genvar g = 0; g < STAGES; g++) begin : g_cell
		tslf_cell #(.STAGE(g), .ROTATE(ROTATE), .SIDE_W(SIDE_W)) u_cell (
			.clk(clk), .en(en), .d(lane[g]), .side_d(side[g]),
			.q(lane[g+1]), .side_q(side[g+1])
		);
	end

	assign q = lane[STAGES];
	assign side_q = side[STAGES];
endmodule

[src/tire_slip_lateral_force_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tire slip and lateral force core
// Slip angles and magic-formula lateral forces for front and rear axles.
// ----------------------------------------------------------------------------
// The core takes one beat per clock while its output is not stalled and returns
// one result beat for each input beat, in order. Three rows of CORDIC cells lie
// on its path: the atan2 row for the slip angles, the atan row for B*slip and
// the sine row for the phase; each holds one iteration per cell. The whole
// pipeline advances only when its last stage is free, so a stalled output holds
// every beat in flight and none is lost.
// Configuration must be written only while the core is idle.
// ----------------------------------------------------------------------------
module tire_slip_lateral_force_core #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] steer_angle,
	input  logic signed [15:0] speed_long,
	input  logic signed [15:0] speed_lat,
	input  logic signed [15:0] yaw_rate,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] slip_front,
	output logic signed [15:0] slip_rear,
	output logic signed [15:0] force_front,
	output logic signed [15:0] force_rear
);
	import tslf_pkg::*;

	localparam logic [2:0] RegFront = 3'd0;
	localparam logic [2:0] RegRear = 3'd1;
	localparam logic [2:0] RegStiff = 3'd2;
	localparam logic [2:0] RegShape = 3'd3;
	localparam logic [2:0] RegMass = 3'd4;
	localparam int LAT = 3 * CORDIC_STAGES + 12;

	// Configuration registers.
	logic [14:0] front_q, rear_q;
	logic [15:0] stiff_q, shape_q;
	logic [12:0] mass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= 15'd4915;
			rear_q <= 15'd6554;
			stiff_q <= 16'd2560;
			shape_q <= 16'd5325;
			mass_q <= 13'd1500;
		end else if (cfg_we) begin
			case (cfg_index)
				RegFront: front_q <= cfg_data[14:0];
				RegRear:  rear_q <= cfg_data[14:0];
				RegStiff: stiff_q <= cfg_data;
				RegShape: shape_q <= cfg_data;
				RegMass:  mass_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// Pipeline control: a valid bit per stage, all stages move together.
	logic [LAT-1:0] vld_q;
	logic           en;

	assign en = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	// Stage 1: register the inputs.
	logic signed [15:0] steer_s1, vx_s1, vy_s1, yaw_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			steer_s1 <= steer_angle;
			vx_s1 <= speed_long;
			vy_s1 <= speed_lat;
			yaw_s1 <= yaw_rate;
		end
	end

	// Stage 2: lateral speeds at each axle, 24 fraction bits.
	vec_t vx_s2, yf_s2, yr_s2;
	logic signed [15:0] steer_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			vx_s2 <= vec_t'(vx_s1) <<< 17;
			yf_s2 <= (vec_t'(vy_s1) <<< 17) + vec_t'($signed({1'b0, front_q}) * yaw_s1);
			yr_s2 <= (vec_t'(vy_s1) <<< 17) - vec_t'($signed({1'b0, rear_q}) * yaw_s1);
			steer_s2 <= steer_s1;
		end
	end

	// Stage 3: quadrant fold for atan2; side data keeps offsets and zero flags.
	localparam int SW1 = 16 + 4;
	cordic_t vf_in, vr_in, vf_out, vr_out;
	logic [SW1-1:0] sf_in, sf_out;
	logic [1:0] sr_in, sr_out;
	logic neg_x, zf, zr;

	always_comb begin
		neg_x = vx_s2 < 0;
		zf = (vx_s2 == 0) && (yf_s2 == 0);
		zr = (vx_s2 == 0) && (yr_s2 == 0);
		vf_in.x = neg_x ? -vx_s2 : vx_s2;
		vf_in.y = neg_x ? -yf_s2 : yf_s2;
		vf_in.z = '0;
		vr_in.x = vf_in.x;
		vr_in.y = neg_x ? -yr_s2 : yr_s2;
		vr_in.z = '0;
		// Offset code: sf bits 3:2, sr bits 1:0; upper = add offset, lower = offset is negative.
		sf_in = {steer_s2, neg_x, (yf_s2 < 0), zf, zr};
		sr_in = {neg_x, (yr_s2 < 0)};
	end

	logic [SW1-1:0] sf_s3;
	logic [1:0]     sr_s3;
	cordic_t        vf_s3, vr_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			vf_s3 <= vf_in;
			vr_s3 <= vr_in;
			sf_s3 <= sf_in;
			sr_s3 <= sr_in;
		end
	end

	tslf_chain #(.STAGES(CORDIC_STAGES), .ROTATE(1'b0), .SIDE_W(SW1)) u_atan2_f (
		.clk(clk), .en(en), .d(vf_s3), .side_d(sf_s3), .q(vf_out), .side_q(sf_out)
	);
	tslf_chain #(.STAGES(CORDIC_STAGES), .ROTATE(1'b0), .SIDE_W(2)) u_atan2_r (
		.clk(clk), .en(en), .d(vr_s3), .side_d(sr_s3), .q(vr_out), .side_q(sr_out)
	);

	// Stage 4: finish the slip angles, round to Q3.12 and saturate.
	function automatic logic signed [15:0] rnd_sat16(input logic signed [AngW+1:0] v);
		logic signed [AngW+1:0] m, r;
		begin
			m = (v < 0) ? -v : v;
			r = (m + (36'sd1 <<< 15)) >>> 16;
			r = (v < 0) ? -r : r;
			if (r > 36'sd32767) return 16'sh7fff;
			else if (r < -36'sd32768) return -16'sh8000;
			else return r[15:0];
		end
	endfunction

	logic signed [AngW+1:0] af, ar;
	ang_t angf, angr;
	always_comb begin
		angf = vf_out.z;
		if (sf_out[1]) angf = '0;
		else if (sf_out[3]) angf = vf_out.z + (sf_out[2] ? -AngPi : AngPi);
		angr = vr_out.z;
		if (sf_out[0]) angr = '0;
		else if (sr_out[1]) angr = vr_out.z + (sr_out[0] ? -AngPi : AngPi);
		af = ((AngW+2)'($signed(sf_out[SW1-1:4])) <<< 16) - (AngW+2)'(angf);
		ar = -(AngW+2)'(angr);
	end

	logic signed [15:0] slf_s4, slr_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			slf_s4 <= rnd_sat16(af);
			slr_s4 <= rnd_sat16(ar);
		end
	end

	// Stage 5: B * slip, 20 fraction bits, against x = 1.0.
	cordic_t bf_s5, br_s5, bf_out, br_out;
	logic [31:0] sl_s5, sl_out;
	always_ff @(posedge clk) begin
		if (en) begin
			bf_s5.x <= vec_t'(1) <<< 20;
			bf_s5.y <= vec_t'($signed({1'b0, stiff_q}) * slf_s4);
			bf_s5.z <= '0;
			br_s5.x <= vec_t'(1) <<< 20;
			br_s5.y <= vec_t'($signed({1'b0, stiff_q}) * slr_s4);
			br_s5.z <= '0;
			sl_s5 <= {slf_s4, slr_s4};
		end
	end

	tslf_chain #(.STAGES(CORDIC_STAGES), .ROTATE(1'b0), .SIDE_W(32)) u_atan_f (
		.clk(clk), .en(en), .d(bf_s5), .side_d(sl_s5), .q(bf_out), .side_q(sl_out)
	);
	tslf_chain #(.STAGES(CORDIC_STAGES), .ROTATE(1'b0), .SIDE_W(1)) u_atan_r (
		.clk(clk), .en(en), .d(br_s5), .side_d(1'b0), .q(br_out), .side_q()
	);

	// Stage 6: C * atan, registered product.
	logic signed [AngW+17:0] pf_s6, pr_s6;
	logic [31:0] sl_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			pf_s6 <= $signed({1'b0, shape_q}) * bf_out.z;
			pr_s6 <= $signed({1'b0, shape_q}) * br_out.z;
			sl_s6 <= sl_out;
		end
	end

	// Stage 7: round the phase to 28 fraction bits; keep magnitude and sign.
	function automatic logic signed [AngW+17:0] rnd12(input logic signed [AngW+17:0] v);
		logic signed [AngW+17:0] m, r;
		begin
			m = (v < 0) ? -v : v;
			r = (m + 2048) >>> 12;
			return (v < 0) ? -r : r;
		end
	endfunction

	logic signed [AngW+17:0] phf, phr;
	assign phf = rnd12(pf_s6);
	assign phr = rnd12(pr_s6);

	ang_t tf_s7, tr_s7;
	logic nf_s7, nr_s7;
	logic [31:0] sl_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			// |phase| < 2^33 in this scale, so its magnitude fits in AngW bits.
			tf_s7 <= ang_t'(phf < 0 ? -phf : phf);
			tr_s7 <= ang_t'(phr < 0 ? -phr : phr);
			nf_s7 <= phf < 0;
			nr_s7 <= phr < 0;
			sl_s7 <= sl_s6;
		end
	end

	// Magnitude of the phase stays below 2^34, so a 34-bit unsigned view is
	// exact. Reduction modulo 2*pi uses a reciprocal estimate and corrections.
	localparam int RecipSh = 48;
	localparam logic [47:0] Recip = 48'd166886; // floor(2^48 / two_pi)

	// Stage 8: quotient estimate (multiply).
	logic [33:0] uf_s8, ur_s8;
	logic [51:0] qf_s8, qr_s8;
	logic nf_s8, nr_s8;
	logic [31:0] sl_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			uf_s8 <= tf_s7;
			ur_s8 <= tr_s7;
			qf_s8 <= 52'(tf_s7[33:0]) * 52'(Recip[17:0]);
			qr_s8 <= 52'(tr_s7[33:0]) * 52'(Recip[17:0]);
			nf_s8 <= nf_s7;
			nr_s8 <= nr_s7;
			sl_s8 <= sl_s7;
		end
	end

	// Stage 9: remainder = t - q * two_pi (q is small); the corrections follow in stage 10.
	logic [33:0] rf_s9, rr_s9;
	logic nf_s9, nr_s9;
	logic [31:0] sl_s9;
	always_ff @(posedge clk) begin
		if (en) begin
			rf_s9 <= 34'(uf_s8 - 34'(qf_s8[51:RecipSh] * 34'(AngTwoPi)));
			rr_s9 <= 34'(ur_s8 - 34'(qr_s8[51:RecipSh] * 34'(AngTwoPi)));
			nf_s9 <= nf_s8;
			nr_s9 <= nr_s8;
			sl_s9 <= sl_s8;
		end
	end

	// Stage 10: final correction and folding into [-pi/2, pi/2].
	function automatic ang_t fold(input logic [33:0] r0);
		ang_t t;
		begin
			t = (r0 >= 34'(AngTwoPi)) ? ang_t'(r0 - 34'(AngTwoPi)) : ang_t'(r0);
			if (t > AngPi) t = t - AngTwoPi;
			if (t > AngHalfPi) t = AngPi - t;
			else if (t < -AngHalfPi) t = -AngPi - t;
			return t;
		end
	endfunction

	cordic_t sf_in2, sr_in2, sf_out2, sr_out2;
	logic [33:0] sd_s10, sd_out;
	always_ff @(posedge clk) begin
		if (en) begin
			sf_in2.x <= vec_t'(InvGain);
			sf_in2.y <= '0;
			sf_in2.z <= fold(rf_s9);
			sr_in2.x <= vec_t'(InvGain);
			sr_in2.y <= '0;
			sr_in2.z <= fold(rr_s9);
			sd_s10 <= {nf_s9, nr_s9, sl_s9};
		end
	end

	tslf_chain #(.STAGES(CORDIC_STAGES), .ROTATE(1'b1), .SIDE_W(34)) u_sin_f (
		.clk(clk), .en(en), .d(sf_in2), .side_d(sd_s10), .q(sf_out2), .side_q(sd_out)
	);
	tslf_chain #(.STAGES(CORDIC_STAGES), .ROTATE(1'b1), .SIDE_W(1)) u_sin_r (
		.clk(clk), .en(en), .d(sr_in2), .side_d(1'b0), .q(sr_out2), .side_q()
	);

	// Stage 11: signed sine times mass * 981.
	logic signed [63:0] mf_s11, mr_s11;
	logic [31:0] sl_s11;
	logic signed [31:0] sinf, sinr;
	assign sinf = sd_out[33] ? -32'(sf_out2.y) : 32'(sf_out2.y);
	assign sinr = sd_out[32] ? -32'(sr_out2.y) : 32'(sr_out2.y);
	logic [22:0] mk;
	assign mk = 23'(mass_q) * 23'd981;
	always_ff @(posedge clk) begin
		if (en) begin
			mf_s11 <= $signed({1'b0, mk}) * sinf;
			mr_s11 <= $signed({1'b0, mk}) * sinr;
			sl_s11 <= sd_out[31:0];
		end
	end

	// Stage 12: divide by 200 * 2^28 with rounding and saturate.
	// Shift by 31 (2^28 * 8), then divide by 25 through a reciprocal.
	function automatic logic signed [15:0] to_newton(input logic signed [63:0] p);
		logic [63:0] m, a;
		logic [40:0] h;
		logic [79:0] qq;
		logic [40:0] q, r;
		logic [40:0] res;
		begin
			m = (p < 0) ? 64'(-p) : 64'(p);
			a = m + 64'd26843545600; // half of the divisor
			h = 41'(a >> 31);
			// floor(h / 25): h < 2^33, exact with a 39-bit reciprocal.
			qq = 80'(h) * 80'd21990232556; // ceil(2^39 / 25)
			q = 41'(qq >> 39);
			r = h - 41'(q * 41'd25);
			if (r >= 41'd25) q = q + 41'd1;
			res = q;
			if (p < 0) return (res > 41'd32768) ? -16'sh8000 : -$signed(res[15:0]);
			return (res > 41'd32767) ? 16'sh7fff : $signed(res[15:0]);
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			slip_front <= sl_s11[31:16];
			slip_rear <= sl_s11[15:0];
			force_front <= to_newton(mf_s11);
			force_rear <= to_newton(mr_s11);
		end
	end
endmodule

[src/tslf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the core's ports for handshake and pipeline behavior.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tslf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [15:0] slip_front
);
	// A stalled result stays up.
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// A stalled result keeps its payload.
	`CHK_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(slip_front))
	// The core is ready whenever its output is free.
	`CHK_IMPL(a_ready_free, clk, arst_n, !out_valid || out_ready, in_ready)
	// Ready drops only under output back-pressure.
	`CHK_IMPL(a_ready_stall, clk, arst_n, !in_ready, out_valid && !out_ready)
endmodule

bind tire_slip_lateral_force_core tslf_checker u_tslf_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .slip_front(slip_front)
);

[dv/tire_slip_lateral_force_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tire slip and lateral force core test
// Drives steering and motion beats through the core under several register
// settings and checks every result beat, field by field, against a fixed-point
// prediction of the slip angles and magic-formula forces kept in this bench.
// ----------------------------------------------------------------------------
module tire_slip_lateral_force_core_test;

	localparam int Stages = 16;
	// Mirrors the core's LAT; DrainCycles adds a margin on top.
	localparam int Latency = 3 * Stages + 12;
	localparam int DrainCycles = Latency + 10;
	localparam int RandomPerPhase = 230;

	// Register indexes in the order of the register map.
	typedef enum logic [2:0] {
		REG_FRONT_DIST = 3'd0,
		REG_REAR_DIST  = 3'd1,
		REG_STIFFNESS  = 3'd2,
		REG_SHAPE      = 3'd3,
		REG_MASS       = 3'd4,
		REG_SPARE5     = 3'd5,
		REG_SPARE6     = 3'd6,
		REG_SPARE7     = 3'd7
	} reg_index_t;

	// Angles carry 28 fraction bits; pi and its relatives in that scale.
	localparam longint AngPi = 64'sd843314856;
	localparam longint AngHalfPi = 64'sd421657428;
	localparam longint AngTwoPi = 64'sd1686629713;
	localparam longint InvGain = 64'sd163008219;
	localparam longint ArctanTab [24] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
		2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128, 64, 32
	};

	typedef struct packed {
		logic [15:0] steer;
		logic [15:0] vlong;
		logic [15:0] vlat;
		logic [15:0] yaw;
	} motion_t;

	typedef struct packed {
		logic [15:0] slip_f;
		logic [15:0] slip_r;
		logic [15:0] force_f;
		logic [15:0] force_r;
	} tire_result_t;

	// A directed row: the motion beat, and where the slips can be read off
	// directly, the slip values typed in.
	typedef struct packed {
		motion_t     motion;
		logic        slips_known;
		logic [15:0] slip_f;
		logic [15:0] slip_r;
	} motion_row_t;

	localparam int DirRows = 22;
	localparam motion_row_t MotionTable [DirRows] = '{
		// Standing still: atan2 of the zero vector is zero, so both slips are zero.
		'{'{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 16'h0000, 16'h0000},
		// Standing still, full steering lock either way: the front slip is the steer.
		'{'{16'h7FFF, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 16'h7FFF, 16'h0000},
		'{'{16'h8000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 16'h8000, 16'h0000},
		// Straight ahead and straight back (reverse turns the vector by pi).
		'{'{16'h0000, 16'h7FFF, 16'h0000, 16'h0000}, 1'b0, 16'h0, 16'h0},
		'{'{16'h0000, 16'h8000, 16'h0000, 16'h0000}, 1'b0, 16'h0, 16'h0},
		'{'{16'h0000, 16'hFF80, 16'h0000, 16'h0000}, 1'b0, 16'h0, 16'h0},
		'{'{16'h0000, 16'hFF80, 16'hFFFF, 16'h0000}, 1'b0, 16'h0, 16'h0},
		'{'{16'h0000, 16'hFF80, 16'h0001, 16'h0000}, 1'b0, 16'h0, 16'h0},
		// Pure lateral motion and pure yaw with no forward speed.
		'{'{16'h0000, 16'h0000, 16'h7FFF, 16'h0000}, 1'b0, 16'h0, 16'h0},
		'{'{16'h0000, 16'h0000, 16'h8000, 16'h0000}, 1'b0, 16'h0, 16'h0},
		'{'{16'h0000, 16'h0000, 16'h0000, 16'h7FFF}, 1'b0, 16'h0, 16'h0},
		'{'{16'h0000, 16'h0000, 16'h0000, 16'h8000}, 1'b0, 16'h0, 16'h0},
		'{'{16'h0000, 16'h0000, 16'h0000, 16'h0001}, 1'b0, 16'h0, 16'h0},
		// Smallest speeds.
		'{'{16'h0000, 16'h0001, 16'h0000, 16'h0000}, 1'b0, 16'h0, 16'h0},
		'{'{16'h0000, 16'hFFFF, 16'h0001, 16'h0000}, 1'b0, 16'h0, 16'h0},
		// Ordinary cornering.
		'{'{16'h1000, 16'h0A00, 16'h0000, 16'h0000}, 1'b0, 16'h0, 16'h0},
		'{'{16'hF000, 16'h0A00, 16'h0080, 16'h1000}, 1'b0, 16'h0, 16'h0},
		'{'{16'h0200, 16'h1400, 16'hFF00, 16'hFC00}, 1'b0, 16'h0, 16'h0},
		// Every field at its extremes and alternating bit patterns.
		'{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, 16'h0, 16'h0},
		'{'{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, 16'h0, 16'h0},
		'{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, 16'h0, 16'h0},
		'{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b0, 16'h0, 16'h0}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] steer_angle;
	logic signed [15:0] speed_long;
	logic signed [15:0] speed_lat;
	logic signed [15:0] yaw_rate;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] slip_front;
	logic signed [15:0] slip_rear;
	logic signed [15:0] force_front;
	logic signed [15:0] force_rear;

	// Bench copy of the register file.
	logic [14:0] front_dist;
	logic [14:0] rear_dist;
	logic [15:0] stiff_b;
	logic [15:0] shape_c;
	logic [12:0] mass_kg;

	tire_result_t pending_results[$];
	int fails;

	tire_slip_lateral_force_core #(.CORDIC_STAGES(Stages)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.steer_angle(steer_angle),
		.speed_long(speed_long),
		.speed_lat(speed_lat),
		.yaw_rate(yaw_rate),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.slip_front(slip_front),
		.slip_rear(slip_rear),
		.force_front(force_front),
		.force_rear(force_rear)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// ------------------------------------------------------------------
	// Fixed-point prediction
	// ------------------------------------------------------------------

	// Rounding to nearest with ties away from zero, then a drop of s bits.
	function automatic longint round_drop(longint v, int s);
		longint half;
		half = 64'sd1 <<< (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic longint clamp16(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// Vectoring CORDIC for x >= 0. The arithmetic shift on a signed longint
	// is the floor division that each iteration calls for.
	function automatic longint vector_angle(longint x, longint y);
		longint z;
		longint dx;
		longint dy;
		z = 0;
		for (int i = 0; i < Stages && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += ArctanTab[i];
			end else begin
				x -= dx;
				y += dy;
				z -= ArctanTab[i];
			end
		end
		return z;
	endfunction

	// Full-plane atan2: reverse motion turns the vector by pi first.
	function automatic longint heading_of(longint x, longint y);
		if (x == 0 && y == 0)
			return 0;
		if (x < 0)
			return vector_angle(-x, -y) + ((y >= 0) ? AngPi : -AngPi);
		return vector_angle(x, y);
	endfunction

	function automatic longint sine_q28(longint a);
		logic neg;
		longint t;
		longint x;
		longint y;
		longint dx;
		longint dy;
		neg = a < 0;
		t = neg ? -a : a;
		x = InvGain;
		y = 0;
		// Fold into [-pi/2, pi/2] using the period and sin(pi - t) = sin(t).
		t = t % AngTwoPi;
		if (t > AngPi)
			t -= AngTwoPi;
		if (t > AngHalfPi)
			t = AngPi - t;
		else if (t < -AngHalfPi)
			t = -AngPi - t;
		for (int i = 0; i < Stages && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (t >= 0) begin
				x -= dx;
				y += dy;
				t -= ArctanTab[i];
			end else begin
				x += dx;
				y -= dy;
				t += ArctanTab[i];
			end
		end
		return neg ? -y : y;
	endfunction

	// Magic formula D*sin(C*atan(B*slip)) in whole newtons.
	function automatic longint lateral_force(longint slip);
		longint phase;
		longint sn;
		longint prod;
		longint mag;
		longint quot;
		longint divisor;
		phase = round_drop(longint'(shape_c) *
			vector_angle(64'sd1 <<< 20, longint'(stiff_b) * slip), 12);
		sn = sine_q28(phase);
		prod = longint'(mass_kg) * 981 * sn;
		divisor = 64'sd200 <<< 28;
		mag = (prod < 0) ? -prod : prod;
		quot = (mag + divisor / 2) / divisor;
		return clamp16((prod < 0) ? -quot : quot);
	endfunction

	function automatic tire_result_t predict_tires(motion_t m);
		tire_result_t r;
		longint vx;
		longint vy;
		longint yaw;
		longint sf;
		longint sr;
		vx = longint'($signed(m.vlong)) * 131072;
		vy = longint'($signed(m.vlat)) * 131072;
		yaw = longint'($signed(m.yaw));
		sf = clamp16(round_drop(longint'($signed(m.steer)) * 65536 -
			heading_of(vx, vy + longint'(front_dist) * yaw), 16));
		sr = clamp16(round_drop(-heading_of(vx, vy - longint'(rear_dist) * yaw), 16));
		r.slip_f = sf[15:0];
		r.slip_r = sr[15:0];
		r.force_f = 16'(lateral_force(sf));
		r.force_r = 16'(lateral_force(sr));
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Each register write is set up at a falling edge; the enable is lowered by the caller
	// once the batch is done, so it is never dropped and raised in one step.
	task automatic write_reg(reg_index_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_FRONT_DIST: front_dist = value[14:0];
			REG_REAR_DIST: rear_dist = value[14:0];
			REG_STIFFNESS: stiff_b = value;
			REG_SHAPE: shape_c = value;
			REG_MASS: mass_kg = value[12:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [15:0] fd, logic [15:0] rd, logic [15:0] b,
			logic [15:0] c, logic [15:0] m);
		write_reg(REG_FRONT_DIST, fd);
		write_reg(REG_REAR_DIST, rd);
		write_reg(REG_STIFFNESS, b);
		write_reg(REG_SHAPE, c);
		write_reg(REG_MASS, m);
		// Unused indexes must leave the register file alone.
		write_reg(REG_SPARE5, 16'($urandom));
		write_reg(REG_SPARE6, 16'($urandom));
		write_reg(REG_SPARE7, 16'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every result beat is back and the pipeline has drained.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Presents one beat and holds it until it is taken.
	task automatic send_beat(motion_t m);
		@(negedge clk);
		in_valid <= 1'b1;
		steer_angle <= m.steer;
		speed_long <= m.vlong;
		speed_lat <= m.vlat;
		yaw_rate <= m.yaw;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(predict_tires(m));
	endtask

	function automatic logic [15:0] corner_value();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'h0001;
			2: return 16'hFFFF;
			3: return 16'h7FFF;
			default: return 16'h8000;
		endcase
	endfunction

	// Mostly plausible driving states, some raw noise and some corner values.
	function automatic motion_t random_motion();
		motion_t m;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			m.steer = 16'($urandom_range(0, 4000)) - 16'd2000;
			m.vlong = (pick < 60) ? 16'($urandom_range(0, 6000)) :
				16'd0 - 16'($urandom_range(0, 2000));
			m.vlat = 16'($urandom_range(0, 1000)) - 16'd500;
			m.yaw = 16'($urandom_range(0, 8000)) - 16'd4000;
		end else if (pick < 85) begin
			m = motion_t'({$urandom, $urandom});
		end else begin
			m.steer = corner_value();
			m.vlong = corner_value();
			m.vlat = corner_value();
			m.yaw = corner_value();
		end
		return m;
	endfunction

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------
	initial begin
		motion_row_t row;
		tire_result_t want;
		int burst;
		fails = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FRONT_DIST;
		cfg_data = '0;
		in_valid = 1'b0;
		steer_angle = '0;
		speed_long = '0;
		speed_lat = '0;
		yaw_rate = '0;
		front_dist = 15'd4915;
		rear_dist = 15'd6554;
		stiff_b = 16'd2560;
		shape_c = 16'd5325;
		mass_kg = 13'd1500;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows run under the reset values, back to back.
		for (int i = 0; i < DirRows; i++) begin
			row = MotionTable[i];
			send_beat(row.motion);
			if (row.slips_known) begin
				want = pending_results.pop_back();
				want.slip_f = row.slip_f;
				want.slip_r = row.slip_r;
				pending_results.push_back(want);
			end
		end

		// Random phases: reset values, the top of every range, all zero,
		// then two random settings. Each phase begins on an idle core, which
		// also gives the sender a pause until every result is back.
		for (int phase = 0; phase < 5; phase++) begin
			wait_idle();
			case (phase)
				1: configure(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
				3: configure(16'($urandom_range(2000, 8000)), 16'($urandom_range(2000, 8000)),
					16'($urandom_range(1000, 4000)), 16'($urandom_range(4000, 7000)),
					16'($urandom_range(500, 6000)));
				4: configure(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
				default: ;
			endcase
			burst = 0;
			for (int n = 0; n < RandomPerPhase; n++) begin
				if (burst == 0) begin
					burst = $urandom_range(1, 40);
					// Roughly half the bursts start with no gap at all.
					if ($urandom_range(0, 1)) begin
						@(negedge clk);
						in_valid <= 1'b0;
						repeat ($urandom_range(0, 12)) @(negedge clk);
					end
				end
				send_beat(random_motion());
				burst--;
			end
		end

		wait_idle();
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: the ready pattern switches at random on a tick counter between
	// always ready, a coin toss and a fixed stall train.
	// ------------------------------------------------------------------
	int ready_mode;
	int ready_tick;
	int stall_len;
	initial begin
		out_ready = 1'b0;
		ready_mode = 0;
		ready_tick = 0;
		stall_len = 3;
	end

	always @(negedge clk) begin
		ready_tick <= ready_tick + 1;
		if (ready_tick % 64 == 63) begin
			ready_mode <= $urandom_range(0, 2);
			stall_len <= $urandom_range(1, 9);
		end
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom);
			default: out_ready <= (ready_tick % (stall_len + 4)) >= stall_len;
		endcase
	end

	// Result checking against the oldest pending prediction.
	always @(posedge clk) begin
		tire_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no prediction pending");
				fails++;
			end else begin
				want = pending_results.pop_front();
				if (slip_front !== want.slip_f) begin
					$error("slip_front expected %0d got %0d", $signed(want.slip_f), slip_front);
					fails++;
				end
				if (slip_rear !== want.slip_r) begin
					$error("slip_rear expected %0d got %0d", $signed(want.slip_r), slip_rear);
					fails++;
				end
				if (force_front !== want.force_f) begin
					$error("force_front expected %0d got %0d", $signed(want.force_f),
						force_front);
					fails++;
				end
				if (force_rear !== want.force_r) begin
					$error("force_rear expected %0d got %0d", $signed(want.force_r),
						force_rear);
					fails++;
				end
			end
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
